@@ hw/rtl/mws_pkg.sv @@
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and constants of the minimum window subsequence core: item
// structs, register indexes and pipeline control.
// ----------------------------------------------------------------------------
package mws_pkg;

	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 64;
	localparam int PLEN_W      = 5;
	localparam int START_OUT_W = 16;
	localparam int LEN_OUT_W   = 17;

	typedef enum logic [1:0] {
		REG_PATTERN_LEN = 2'd0,
		REG_PATTERN_LO  = 2'd1,
		REG_PATTERN_HI  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              last;
	} text_t;

	typedef struct packed {
		logic                   found;
		logic [START_OUT_W-1:0] window_start;
		logic [LEN_OUT_W-1:0]   window_len;
		logic                   too_long;
	} result_t;

	typedef struct packed {
		logic vld;
		logic last;
		logic cand_vld;
		logic ovf;
	} stage_ctl_t;

endpackage

@@ hw/rtl/mws_cell.sv @@
// ----------------------------------------------------------------------------
// mws_cell
// One pattern position: holds the start index of the latest partial match
// and takes its left neighbor's start when the text byte hits its character.
// ----------------------------------------------------------------------------
module mws_cell import mws_pkg::*; #(
	parameter int SW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              clr,
	input  logic [CHAR_W-1:0] pat_char,
	input  logic [CHAR_W-1:0] text_char,
	input  logic [SW-1:0]     prv_start,
	input  logic              prv_vld,
	output logic [SW-1:0]     nxt_start,
	output logic              nxt_vld,
	output logic [SW-1:0]     start_q,
	output logic              vld_q
);

	logic hit;

	assign hit       = pat_char == text_char;
	assign nxt_start = hit ? prv_start : start_q;
	assign nxt_vld   = hit ? prv_vld : vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= nxt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_q <= nxt_start;
		end
	end

endmodule

@@ hw/rtl/mws_best.sv @@
// ----------------------------------------------------------------------------
// mws_best
// Best window tracker: keeps the shortest window seen so far and drives the
// result register on the last item of a text.
// ----------------------------------------------------------------------------
module mws_best import mws_pkg::*; #(
	parameter int PW = 17,
	parameter int SW = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl,
	input  logic [SW-1:0] cand_start,
	input  logic [SW-1:0] cand_pos,
	input  logic       result_stall,
	output logic       adv,
	output logic       result_valid,
	output result_t    result
);

	logic [PW-1:0] len;
	logic          take;
	logic          have_q;
	logic [SW-1:0] bstart_q;
	logic [PW-1:0] blen_q;
	logic          nb_have;
	logic [SW-1:0] nb_start;
	logic [PW-1:0] nb_len;
	logic          emit;

	assign adv  = !(ctl.vld && ctl.last && result_valid && result_stall);
	assign len  = PW'(cand_pos) - PW'(cand_start) + PW'(1);
	assign take = ctl.cand_vld && (!have_q || len < blen_q);
	assign emit = adv && ctl.vld && ctl.last;

	always_comb begin
		nb_have  = have_q;
		nb_start = bstart_q;
		nb_len   = blen_q;
		if (take) begin
			nb_have  = 1'b1;
			nb_start = cand_start;
			nb_len   = len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			bstart_q <= '0;
			blen_q   <= '0;
		end else if (adv && ctl.vld) begin
			if (ctl.last) begin
				have_q   <= 1'b0;
				bstart_q <= '0;
				blen_q   <= '0;
			end else begin
				have_q   <= nb_have;
				bstart_q <= nb_start;
				blen_q   <= nb_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result.found        <= nb_have;
			result.window_start <= nb_have ? START_OUT_W'(nb_start) : '0;
			result.window_len   <= nb_have ? LEN_OUT_W'(nb_len) : '0;
			result.too_long     <= ctl.ovf;
		end
	end

endmodule

@@ hw/rtl/min_window_subsequence_core.sv @@
// ----------------------------------------------------------------------------
// min_window_subsequence_core
// Shortest text window that holds the configured pattern as a subsequence.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while text_stall is low. A row of MAX_PATTERN
// cells, one per pattern character, updates the partial match starts of the
// active cells in the same cycle from the byte; a second stage compares the
// completed window against the best one. A text's result is registered once
// its last byte has passed the compare stage; new bytes keep flowing while a
// result waits, unless a second last byte reaches the compare stage before the
// first result leaves. Write the pattern registers only between texts.
module min_window_subsequence_core import mws_pkg::*; #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_TEXT    = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	output logic             text_stall,
	input  text_t            text,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int PW = $clog2(MAX_TEXT + 1);
	localparam int SW = $clog2(MAX_TEXT);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [PLEN_W-1:0]  plen_q;
	logic [CFG_W-1:0]   pat_lo_q;
	logic [CFG_W-1:0]   pat_hi_q;
	logic [2*CFG_W-1:0] pat;
	logic [PLEN_W-1:0]  m_eff;
	logic [IW-1:0]      m_idx;

	logic          adv;
	logic          acc;
	logic          upd;
	logic          clr;
	logic          pos_full;
	logic [PW-1:0] pos_q;
	logic          ovf_q;

	logic [MAX_PATTERN-1:0] active;
	logic [SW-1:0]          nxt_start [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] nxt_vld;
	logic [SW-1:0]          start_q   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] vld_q;

	stage_ctl_t    ctl_s1;
	logic [SW-1:0] start_s1;
	logic [SW-1:0] pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= PLEN_W'(1);
			pat_lo_q <= '0;
			pat_hi_q <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PATTERN_LEN: plen_q   <= cfg_data[PLEN_W-1:0];
				REG_PATTERN_LO:  pat_lo_q <= cfg_data;
				REG_PATTERN_HI:  pat_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pat = {pat_hi_q, pat_lo_q};

	always_comb begin
		m_eff = plen_q;
		if (plen_q == '0) begin
			m_eff = PLEN_W'(1);
		end else if (plen_q > PLEN_W'(MAX_PATTERN)) begin
			m_eff = PLEN_W'(MAX_PATTERN);
		end
	end

	assign m_idx = IW'(m_eff - PLEN_W'(1));

	assign text_stall = !adv;
	assign acc        = text_valid && adv;
	assign pos_full   = pos_q == PW'(MAX_TEXT);
	assign upd        = acc && !pos_full;
	assign clr        = acc && text.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			if (text.last) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else if (pos_full) begin
				ovf_q <= 1'b1;
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [SW-1:0] prv_start;
		logic          prv_vld;

		if (j == 0) begin : g_head
			assign prv_start = SW'(pos_q);
			assign prv_vld   = 1'b1;
		end else begin : g_link
			assign prv_start = start_q[j-1];
			assign prv_vld   = vld_q[j-1];
		end

		assign active[j] = PLEN_W'(j) < m_eff;

		mws_cell #(
			.SW(SW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (upd && active[j]),
			.clr       (clr),
			.pat_char  (pat[CHAR_W*j +: CHAR_W]),
			.text_char (text.text_char),
			.prv_start (prv_start),
			.prv_vld   (prv_vld),
			.nxt_start (nxt_start[j]),
			.nxt_vld   (nxt_vld[j]),
			.start_q   (start_q[j]),
			.vld_q     (vld_q[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld      <= acc;
			ctl_s1.last     <= text.last;
			ctl_s1.cand_vld <= upd && nxt_vld[m_idx];
			ctl_s1.ovf      <= ovf_q || pos_full;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			start_s1 <= nxt_start[m_idx];
			pos_s1   <= SW'(pos_q);
		end
	end

	mws_best #(
		.PW(PW),
		.SW(SW)
	) u_best (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_s1),
		.cand_start   (start_s1),
		.cand_pos     (pos_s1),
		.result_stall (result_stall),
		.adv          (adv),
		.result_valid (result_valid),
		.result       (result)
	);

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> pos_q == '0 && !ovf_q)
		else $error("position not cleared after last item");

	a_cells_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> vld_q == '0)
		else $error("match cells not cleared after last item");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_TEXT))
		else $error("position beyond text limit");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl_s1) && $stable(pos_s1))
		else $error("compare stage changed while held");

endmodule
